>>> sv/pmul_pkg.sv
package pmul_pkg;

    localparam int MAX_DEGREE_DEF = 31;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int DEG_W          = 5;
    localparam int KPOW_W         = 6;
    localparam int OUT_W          = 37;
    localparam int OUT_TDATA_W    = ((KPOW_W + OUT_W + 7) / 8) * 8;
    localparam int STEP_W         = 3;

    // Step addresses of the microprogram.
    localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] ST_KINIT  = 3'd1;
    localparam logic [STEP_W-1:0] ST_IINIT  = 3'd2;
    localparam logic [STEP_W-1:0] ST_MAC    = 3'd3;
    localparam logic [STEP_W-1:0] ST_DRAIN1 = 3'd4;
    localparam logic [STEP_W-1:0] ST_DRAIN2 = 3'd5;
    localparam logic [STEP_W-1:0] ST_EMIT   = 3'd6;
    localparam logic [STEP_W-1:0] ST_NEXT   = 3'd7;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_LOAD_LAST = 3'd1,
        C_ISSUE_END = 3'd2,
        C_OUT_BUSY  = 3'd3,
        C_K_FINAL   = 3'd4
    } t_cond;

    typedef struct packed {
        logic load;
        logic k_clr;
        logic k_inc;
        logic i_init;
        logic issue;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic load_last;
        logic issue_end;
        logic out_busy;
        logic k_final;
    } t_stat;

    typedef struct packed {
        t_ctrl             ctrl;
        t_cond             cond;
        logic [STEP_W-1:0] t_true;
        logic [STEP_W-1:0] t_false;
    } t_uword;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{ctrl: '0, cond: C_NEVER, t_true: ST_IDLE, t_false: ST_IDLE};
        case (step)
            ST_IDLE: begin
                w.ctrl.load = 1'b1;
                w.cond      = C_LOAD_LAST;
                w.t_true    = ST_KINIT;
                w.t_false   = ST_IDLE;
            end
            ST_KINIT: begin
                w.ctrl.k_clr = 1'b1;
                w.t_false    = ST_IINIT;
            end
            ST_IINIT: begin
                w.ctrl.i_init = 1'b1;
                w.t_false     = ST_MAC;
            end
            ST_MAC: begin
                w.ctrl.issue = 1'b1;
                w.cond       = C_ISSUE_END;
                w.t_true     = ST_DRAIN1;
                w.t_false    = ST_MAC;
            end
            ST_DRAIN1: begin
                w.t_false = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                w.t_false = ST_EMIT;
            end
            ST_EMIT: begin
                w.ctrl.emit = 1'b1;
                w.cond      = C_OUT_BUSY;
                w.t_true    = ST_EMIT;
                w.t_false   = ST_NEXT;
            end
            ST_NEXT: begin
                w.ctrl.k_inc = 1'b1;
                w.cond       = C_K_FINAL;
                w.t_true     = ST_IDLE;
                w.t_false    = ST_IINIT;
            end
            default: begin
                w.t_false = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/pmul_seq.sv
module pmul_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmul_pkg::t_stat i_stat,
    output pmul_pkg::t_ctrl o_ctrl
);

    logic [pmul_pkg::STEP_W-1:0] r_step;
    logic [pmul_pkg::STEP_W-1:0] n_step;
    pmul_pkg::t_uword            uw;
    logic                        cond_hit;

    assign uw     = pmul_pkg::ucode(r_step);
    assign o_ctrl = uw.ctrl;

    always_comb begin
        case (uw.cond)
            pmul_pkg::C_NEVER:     cond_hit = 1'b0;
            pmul_pkg::C_LOAD_LAST: cond_hit = i_stat.load_last;
            pmul_pkg::C_ISSUE_END: cond_hit = i_stat.issue_end;
            pmul_pkg::C_OUT_BUSY:  cond_hit = i_stat.out_busy;
            pmul_pkg::C_K_FINAL:   cond_hit = i_stat.k_final;
            default:               cond_hit = 1'b0;
        endcase
        n_step = cond_hit ? uw.t_true : uw.t_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pmul_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> sv/pmul_dp.sv
module pmul_dp #(
    parameter int MAX_DEGREE = pmul_pkg::MAX_DEGREE_DEF,
    parameter int COEF_WIDTH = pmul_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pmul_pkg::t_ctrl                     i_ctrl,
    input  logic                                i_load,
    input  logic                                i_operand_b,
    input  logic [pmul_pkg::DEG_W-1:0]          i_degree,
    input  logic [pmul_pkg::DEG_W-1:0]          i_power,
    input  logic [COEF_WIDTH-1:0]               i_coefficient,
    input  logic                                i_last,
    input  logic                                i_out_ready,
    output pmul_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic [pmul_pkg::KPOW_W-1:0]         o_out_power,
    output logic signed [pmul_pkg::OUT_W-1:0]   o_product_coefficient,
    output logic                                o_final_res
);

    localparam int DEPTH  = MAX_DEGREE + 1;
    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * COEF_WIDTH;
    localparam int KW     = pmul_pkg::KPOW_W;
    localparam int DW     = pmul_pkg::DEG_W;
    localparam int OW     = pmul_pkg::OUT_W;

    logic [COEF_WIDTH-1:0] r_a_mem [DEPTH];
    logic [COEF_WIDTH-1:0] r_b_mem [DEPTH];

    logic [DW-1:0]                r_a_deg;
    logic [DW-1:0]                r_b_deg;
    logic [KW-1:0]                r_k;
    logic [IW-1:0]                r_i;
    logic [IW-1:0]                r_end;
    logic                         r_rd_v;
    logic                         r_mul_v;
    logic signed [COEF_WIDTH-1:0] r_a_q;
    logic signed [COEF_WIDTH-1:0] r_b_q;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [OW-1:0]         r_acc;
    logic                         r_ov;
    logic [KW-1:0]                r_out_power;
    logic signed [OW-1:0]         r_out_coef;
    logic                         r_out_final;

    logic [DW-1:0] deg_sat;
    logic          pow_ok;
    logic [IW-1:0] waddr;
    logic [KW-1:0] total;
    logic [KW-1:0] start_k;
    logic [KW-1:0] end_k;
    logic [KW-1:0] j_k;
    logic [IW-1:0] rd_j;
    logic          out_load;

    assign deg_sat = ({1'b0, i_degree} > KW'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : i_degree;
    assign pow_ok  = ({1'b0, i_power} <= KW'(MAX_DEGREE));
    assign waddr   = IW'(i_power);
    assign total   = KW'(r_a_deg) + KW'(r_b_deg);

    // First and last index i that pair with a stored B term for power k.
    assign start_k = (r_k > KW'(r_b_deg)) ? (r_k - KW'(r_b_deg)) : '0;
    assign end_k   = (r_k < KW'(r_a_deg)) ? r_k : KW'(r_a_deg);
    assign j_k     = r_k - KW'(r_i);
    assign rd_j    = IW'(j_k);

    assign out_load = i_ctrl.emit && !(r_ov && !i_out_ready);

    assign o_stat.load_last = i_load && i_last;
    assign o_stat.issue_end = (r_i == r_end);
    assign o_stat.out_busy  = r_ov && !i_out_ready;
    assign o_stat.k_final   = (r_k == total);

    always_ff @(posedge i_clk) begin
        if (i_load && !i_operand_b && pow_ok) begin
            r_a_mem[waddr] <= i_coefficient;
        end
        if (i_load && i_operand_b && pow_ok) begin
            r_b_mem[waddr] <= i_coefficient;
        end
        if (i_ctrl.issue) begin
            r_a_q <= r_a_mem[r_i];
            r_b_q <= r_b_mem[rd_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_deg <= '0;
            r_b_deg <= '0;
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_load && !i_operand_b) begin
                r_a_deg <= deg_sat;
            end
            if (i_load && i_operand_b) begin
                r_b_deg <= deg_sat;
            end
            r_rd_v  <= i_ctrl.issue;
            r_mul_v <= r_rd_v;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.k_clr) begin
            r_k <= '0;
        end else if (i_ctrl.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_ctrl.i_init) begin
            r_i   <= IW'(start_k);
            r_end <= IW'(end_k);
        end else if (i_ctrl.issue) begin
            r_i <= r_i + 1'b1;
        end
        r_prod <= r_a_q * r_b_q;
        // Sums wrap at the output width; the product is sign-extended or cut to fit.
        if (i_ctrl.i_init) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + OW'(r_prod);
        end
        if (out_load) begin
            r_out_power <= r_k;
            r_out_coef  <= r_acc;
            r_out_final <= (r_k == total);
        end
    end

    assign o_out_valid           = r_ov;
    assign o_out_power           = r_out_power;
    assign o_product_coefficient = r_out_coef;
    assign o_final_res           = r_out_final;

    a_init_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.i_init |-> (!r_rd_v && !r_mul_v))
        else $error("accumulator cleared while terms are in flight");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> (!r_rd_v && !r_mul_v))
        else $error("result emitted before the last term was summed");

    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.issue |-> ((KW'(r_i) <= r_k) && (j_k <= KW'(r_b_deg))
                          && (r_i <= IW'(r_a_deg))))
        else $error("term index outside the operand degrees");

endmodule

>>> sv/polynomial_multiplier_unit.sv
// Loads coefficients of polynomials A and B one transaction per cycle (tuser picks the
// operand); the transaction with tlast starts the product, during which no input is taken.
// A single multiply-accumulate pipeline adds one term per cycle; for power k it sums the
// terms A[i]*B[k-i] within both degrees, lets the pipeline drain, then emits the result,
// waiting while the output is stalled, and moves on to the next power of the product.
// Results leave through an output register, the last one marked with tlast.
module polynomial_multiplier_unit #(
    parameter int MAX_DEGREE = pmul_pkg::MAX_DEGREE_DEF,
    parameter int COEF_WIDTH = pmul_pkg::COEF_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // degree[4:0], power[9:5], coefficient, zero fill
    input  logic [((2*pmul_pkg::DEG_W+COEF_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // operand_b
    input  logic                                      i_s_axis_tuser,
    input  logic                                      i_s_axis_tlast,
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // out_power[5:0], product_coefficient[42:6], zero fill
    output logic [pmul_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,
    output logic                                      o_m_axis_tlast
);

    localparam int DW = pmul_pkg::DEG_W;
    localparam int KW = pmul_pkg::KPOW_W;
    localparam int OW = pmul_pkg::OUT_W;

    pmul_pkg::t_ctrl ctrl;
    pmul_pkg::t_stat stat;

    logic                 load;
    logic [KW-1:0]        out_power;
    logic signed [OW-1:0] out_coef;

    assign o_s_axis_tready = ctrl.load;
    assign load            = i_s_axis_tvalid && ctrl.load;

    pmul_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    pmul_dp #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_ctrl                (ctrl),
        .i_load                (load),
        .i_operand_b           (i_s_axis_tuser),
        .i_degree              (i_s_axis_tdata[DW-1:0]),
        .i_power               (i_s_axis_tdata[2*DW-1:DW]),
        .i_coefficient         (i_s_axis_tdata[2*DW+COEF_WIDTH-1:2*DW]),
        .i_last                (i_s_axis_tlast),
        .i_out_ready           (i_m_axis_tready),
        .o_stat                (stat),
        .o_out_valid           (o_m_axis_tvalid),
        .o_out_power           (out_power),
        .o_product_coefficient (out_coef),
        .o_final_res           (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(pmul_pkg::OUT_TDATA_W-KW-OW){1'b0}}, out_coef, out_power};

endmodule

>>> tb/sv/testbench.sv
module testbench;

    localparam int MAX_DEG        = pmul_pkg::MAX_DEGREE_DEF;
    localparam int COEF_W         = pmul_pkg::COEF_WIDTH_DEF;
    localparam int DEG_W          = pmul_pkg::DEG_W;
    localparam int KPOW_W         = pmul_pkg::KPOW_W;
    localparam int OUT_W          = pmul_pkg::OUT_W;
    localparam int OUT_TDATA_W    = pmul_pkg::OUT_TDATA_W;
    localparam int IN_TDATA_W     = ((2*DEG_W + COEF_W + 7) / 8) * 8;
    localparam int TOTAL_LOADS    = 470;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic OPER_A = 1'b0;
    localparam logic OPER_B = 1'b1;

    typedef struct packed {
        logic              op_b;
        logic [DEG_W-1:0]  deg;
        logic [DEG_W-1:0]  pw;
        logic [COEF_W-1:0] coef;
        logic              last;
    } t_coef_load;

    typedef struct packed {
        logic [KPOW_W-1:0] pw;
        logic [OUT_W-1:0]  value;
        logic              fin;
    } t_product;

    // Keeps its own copy of both coefficient stores and degrees and convolves them
    // whenever a transaction carrying tlast is accepted.
    class t_product_scoreboard;
        logic [COEF_W-1:0] a_coef [MAX_DEG+1];
        logic [COEF_W-1:0] b_coef [MAX_DEG+1];
        int unsigned       a_deg = 0;
        int unsigned       b_deg = 0;
        t_product          expected_q [$];
        int                mismatches = 0;

        function void note_load(t_coef_load ld);
            t_product                   p;
            logic signed [OUT_W-1:0]    acc;
            logic signed [2*COEF_W-1:0] term;
            int unsigned                total;
            if (ld.op_b == OPER_B) begin
                b_deg          = ld.deg;
                b_coef[ld.pw]  = ld.coef;
            end else begin
                a_deg          = ld.deg;
                a_coef[ld.pw]  = ld.coef;
            end
            if (!ld.last)
                return;
            total = a_deg + b_deg;
            for (int unsigned k = 0; k <= total; k++) begin
                acc = '0;
                for (int unsigned i = 0; i <= a_deg && i <= k; i++) begin
                    if (k - i <= b_deg) begin
                        term = $signed(a_coef[i]) * $signed(b_coef[k - i]);
                        acc  = acc + term;
                    end
                end
                p.pw    = KPOW_W'(k);
                p.value = acc;
                p.fin   = (k == total);
                expected_q.push_back(p);
            end
        endfunction

        function void check_product(t_product got);
            t_product want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected product power %0d value %0d last %b",
                             $time, got.pw, $signed(got.value), got.fin);
                return;
            end
            want = expected_q.pop_front();
            if (got.pw !== want.pw || got.value !== want.value || got.fin !== want.fin) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: power exp %0d got %0d, value exp %0d got %0d, last exp %b got %b",
                             $time, want.pw, got.pw, $signed(want.value), $signed(got.value),
                             want.fin, got.fin);
            end
        endfunction
    endclass

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    t_coef_load              s_item  = '0;
    logic                    m_ready = 1'b0;
    logic                    s_ready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_valid;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_last;

    t_product_scoreboard sb;
    bit                no_gaps = 1'b0;
    int                idle_cycles = 0;
    int unsigned       loads_sent = 0;
    // Entries written so far and the degrees the block holds, so that a tlast is only
    // issued when every coefficient it will read has been loaded.
    logic [MAX_DEG:0]  wr_a = '0;
    logic [MAX_DEG:0]  wr_b = '0;
    int unsigned       deg_a = 0;
    int unsigned       deg_b = 0;

    assign s_tdata = {{(IN_TDATA_W-2*DEG_W-COEF_W){1'b0}}, s_item.coef, s_item.pw, s_item.deg};

    polynomial_multiplier_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_item.op_b),
        .i_s_axis_tlast  (s_item.last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready)
            sb.note_load(s_item);
        if (i_rst_n && m_valid && m_ready)
            sb.check_product(t_product'{m_tdata[KPOW_W-1:0],
                                        m_tdata[KPOW_W+OUT_W-1:KPOW_W], m_last});
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_coef_load make_load(logic op_b, int unsigned deg, int unsigned pw,
                                             logic [COEF_W-1:0] coef, logic last);
        t_coef_load ld;
        ld.op_b = op_b;
        ld.deg  = DEG_W'(deg);
        ld.pw   = DEG_W'(pw);
        ld.coef = coef;
        ld.last = last;
        return ld;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(COEF_W-1){1'b0}}};
            1: return {1'b0, {(COEF_W-1){1'b1}}};
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_degree();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, MAX_DEG);
        return $urandom_range(0, 5);
    endfunction

    function automatic bit last_allowed(logic op_b, int unsigned deg, int unsigned pw);
        logic [63:0] have_a, have_b, need_a, need_b;
        int unsigned da, db;
        have_a = 64'(wr_a);
        have_b = 64'(wr_b);
        da     = deg_a;
        db     = deg_b;
        if (op_b == OPER_B) begin
            have_b[pw] = 1'b1;
            db         = deg;
        end else begin
            have_a[pw] = 1'b1;
            da         = deg;
        end
        need_a = (64'd2 << da) - 64'd1;
        need_b = (64'd2 << db) - 64'd1;
        return ((have_a & need_a) == need_a) && ((have_b & need_b) == need_b);
    endfunction

    task automatic send_coef(input t_coef_load ld);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_item  <= ld;
        do @(posedge i_clk); while (!(s_valid && s_ready));
        if (ld.op_b == OPER_B) begin
            wr_b[ld.pw] = 1'b1;
            deg_b       = ld.deg;
        end else begin
            wr_a[ld.pw] = 1'b1;
            deg_a       = ld.deg;
        end
        loads_sent++;
    endtask

    // Loads both polynomials in shuffled order. A broken run stops early without tlast.
    task automatic send_run(input int unsigned da, input int unsigned db, input bit complete);
        t_coef_load  seq [2*(MAX_DEG+1)];
        t_coef_load  tmp;
        int unsigned n, j, cut;
        n = 0;
        for (int unsigned p = 0; p <= da; p++) begin
            seq[n] = make_load(OPER_A, da, p, pick_coef(), 1'b0);
            n++;
        end
        for (int unsigned p = 0; p <= db; p++) begin
            seq[n] = make_load(OPER_B, db, p, pick_coef(), 1'b0);
            n++;
        end
        for (int unsigned i = n - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            tmp    = seq[i];
            seq[i] = seq[j];
            seq[j] = tmp;
        end
        seq[n-1].last = complete;
        cut = complete ? n : $urandom_range(1, n - 1);
        for (int unsigned i = 0; i < cut; i++)
            send_coef(seq[i]);
    endtask

    task automatic drain_products();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    initial begin
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            int unsigned stall;
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        int unsigned sel, deg, pw;
        logic        op_b;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Most negative squared, then mixed extremes of degree one.
        send_coef(make_load(OPER_A, 0, 0, 16'h8000, 1'b0));
        send_coef(make_load(OPER_B, 0, 0, 16'h8000, 1'b1));
        send_coef(make_load(OPER_A, 1, 0, 16'h7FFF, 1'b0));
        send_coef(make_load(OPER_A, 1, 1, 16'h8000, 1'b0));
        send_coef(make_load(OPER_B, 1, 1, 16'hFFFF, 1'b0));
        send_coef(make_load(OPER_B, 1, 0, 16'h8000, 1'b1));
        // Overwrite one entry and multiply again with the held degrees.
        send_coef(make_load(OPER_A, 1, 1, 16'h0001, 1'b1));
        // Entry above the degree is stored but must not enter the product.
        send_coef(make_load(OPER_B, 0, 7, 16'h1234, 1'b1));
        send_coef(make_load(OPER_B, 2, 2, 16'h7FFF, 1'b0));
        send_coef(make_load(OPER_A, 2, 0, 16'h0000, 1'b0));
        send_coef(make_load(OPER_A, 2, 2, 16'h8000, 1'b1));
        drain_products();

        send_run(MAX_DEG, MAX_DEG, 1'b1);

        while (loads_sent < TOTAL_LOADS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            sel     = $urandom_range(0, 9);
            if (sel < 6) begin
                send_run(pick_degree(), pick_degree(), 1'b1);
            end else if (sel == 6) begin
                send_run(pick_degree(), pick_degree(), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    op_b = $urandom_range(0, 1);
                    deg  = pick_degree();
                    pw   = $urandom_range(0, MAX_DEG);
                    send_coef(make_load(op_b, deg, pw, pick_coef(),
                                        ($urandom_range(0, 2) == 0) &&
                                        last_allowed(op_b, deg, pw)));
                end
            end
            if ($urandom_range(0, 11) == 0)
                drain_products();
        end
        no_gaps = 1'b0;

        drain_products();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
